[design/assert_macros.svh]
// assertion macros used by the top rtl file, endpoint_packet_buffer_allocator.sv
// clocked on clock, disabled while reset is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[design/epba_pkg.sv]
// package for the endpoint packet buffer allocator
// sizes, codes, state type and helpers; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package epba_pkg;

   localparam int NUM_ENDPOINTS = 8;
   localparam int NUM_SLOTS     = 2 * NUM_ENDPOINTS;
   localparam int SLOT_W        = $clog2(NUM_SLOTS);
   localparam int CNT_W         = $clog2(NUM_SLOTS + 1);
   localparam int EP_W          = 3;
   localparam int EPN_W         = 5;
   localparam int ADDR_W        = 11;
   localparam int SIZE_W        = 10;
   localparam int SUM_W         = ADDR_W + 1;
   localparam int RX_W          = 16;
   localparam int TABLE_BYTES   = NUM_ENDPOINTS * 8;

   localparam logic [ADDR_W-1:0] MEM_BYTES_RESET = 11'd1024;
   localparam logic [ADDR_W-1:0] SMALL_LIMIT     = 11'd62;
   localparam logic [SUM_W-1:0]  BLOCK_ROUND     = 12'h01F;

   typedef enum logic [1:0] {
      OP_CONFIG      = 2'd0,
      OP_RELEASE     = 2'd1,
      OP_RELEASE_ALL = 2'd2,
      OP_NONE        = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      EP_CONTROL   = 2'd0,
      EP_ISO       = 2'd1,
      EP_BULK      = 2'd2,
      EP_INTERRUPT = 2'd3
   } ep_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_READ0,
      ST_READ1,
      ST_LOAD
   } state_type;

   typedef struct packed {
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      logic [ADDR_W-1:0] wr_data;
      logic              clr_one;
      logic [SLOT_W-1:0] clr_addr0;
      logic [SLOT_W-1:0] clr_addr1;
      logic              clr_all;
   } mem_ctrl_type;

   typedef struct packed {
      logic              done;
      logic              fail;
      logic [ADDR_W-1:0] addr;
   } alloc_res_type;

   function automatic logic [SLOT_W-1:0] slot_index(input logic [EP_W-1:0] ep,
                                                    input logic sel);
      logic [EP_W+1:0] wide;
      wide = {1'b0, ep, sel};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

`default_nettype wire

[design/endpoint_packet_buffer_allocator.sv]
// configure: up to two allocations, one per enabled step, with disabled steps skipped;
// release and release-all clear valid bits and need no scan; the slot scan in the
// allocation unit (one slot a cycle through the single memory read port) paces a configure;
// requests are taken one at a time; a finished result waits in the output register
// synchronous active-high reset: all slots free (valid bits cleared), memory size 1024
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module endpoint_packet_buffer_allocator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [10:0] csr_wdata,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [2:0]  req_ep_index,
   input  wire logic        req_is_in,
   input  wire logic [1:0]  req_ep_type,
   input  wire logic        req_double_buffered,
   input  wire logic [9:0]  req_buffer_size,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic [10:0]      rsp_slot0_addr,
   output logic [10:0]      rsp_slot1_addr,
   output logic [15:0]      rsp_rx_count_word
);

   epba_pkg::state_type         state_ff, state_in;
   logic [epba_pkg::ADDR_W-1:0] mem_bytes_ff;
   logic [epba_pkg::EP_W-1:0]   ep_ff, ep_in;
   logic                        ep_ok_ff, ep_ok_in;
   logic [epba_pkg::ADDR_W-1:0] size_e_ff, size_e_in;
   logic [epba_pkg::ADDR_W-1:0] rsz_ff, rsz_in;
   logic [epba_pkg::RX_W-1:0]   rxcnt_ff, rxcnt_in;
   logic [3:0]                  en_ff, en_in;
   logic [2:0]                  step_ff, step_in;
   logic                        status_ff, status_in;
   logic [epba_pkg::ADDR_W-1:0] slot0_ff, slot0_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff;
   logic [epba_pkg::ADDR_W-1:0] rsp_slot0_ff, rsp_slot1_ff;
   logic [epba_pkg::RX_W-1:0]   rsp_rx_ff;

   epba_pkg::mem_ctrl_type      mem_ctrl;
   epba_pkg::alloc_res_type     alloc_res;
   logic [epba_pkg::SLOT_W-1:0] mem_rd_addr, own_rd_addr, alloc_rd_addr;
   logic [epba_pkg::ADDR_W-1:0] mem_rd_data;
   logic                        alloc_start;
   logic [epba_pkg::ADDR_W-1:0] alloc_size;

   logic                        req_fire, out_free, load_out;
   logic [epba_pkg::ADDR_W-1:0] req_size_e;
   logic [epba_pkg::SUM_W-1:0]  round_sum;
   logic [5:0]                  blocks;
   logic [4:0]                  blocks_m1;
   logic [epba_pkg::RX_W-1:0]   req_rx;
   logic [epba_pkg::ADDR_W-1:0] req_rsz;
   logic                        req_two, phase_a, phase_b, req_ep_ok;
   logic                        step_sel;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_bytes_ff <= epba_pkg::MEM_BYTES_RESET;
      end else if (csr_valid && csr_ready) begin
         mem_bytes_ff <= csr_wdata;
      end
   end

   // request decode: even size, receive count word, step plan
   always_comb begin
      req_size_e = {1'b0, req_buffer_size} + epba_pkg::ADDR_W'(req_buffer_size[0]);
      round_sum  = {1'b0, req_size_e} + epba_pkg::BLOCK_ROUND;
      blocks     = round_sum[10:5];
      blocks_m1  = 5'(blocks - 6'd1);
      if (req_size_e > epba_pkg::SMALL_LIMIT) begin
         req_rx  = {1'b1, blocks_m1, 10'b0};
         req_rsz = {blocks, 5'b0};
      end else begin
         req_rx  = {1'b0, req_size_e[5:1], 10'b0};
         req_rsz = req_size_e;
      end
      req_two   = (req_ep_type == epba_pkg::EP_ISO) ||
                  ((req_ep_type == epba_pkg::EP_BULK) && req_double_buffered);
      phase_a   = req_is_in || (req_ep_type == epba_pkg::EP_CONTROL);
      phase_b   = !req_is_in;
      req_ep_ok = {2'b00, req_ep_index} < epba_pkg::EPN_W'(epba_pkg::NUM_ENDPOINTS);
   end

   // step order: slot 0, slot 1 at the even size; slot 1, slot 0 at the receive size
   always_comb begin
      step_sel   = (step_ff == 3'd1) || (step_ff == 3'd2);
      alloc_size = (step_ff < 3'd2) ? size_e_ff : rsz_ff;
   end

   assign req_ready = (state_ff == epba_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in    = state_ff;
      ep_in       = ep_ff;
      ep_ok_in    = ep_ok_ff;
      size_e_in   = size_e_ff;
      rsz_in      = rsz_ff;
      rxcnt_in    = rxcnt_ff;
      en_in       = en_ff;
      step_in     = step_ff;
      status_in   = status_ff;
      slot0_in    = slot0_ff;
      alloc_start = 1'b0;
      load_out    = 1'b0;
      own_rd_addr = epba_pkg::slot_index(ep_ff, 1'b1);
      mem_ctrl    = '0;
      mem_ctrl.wr_addr   = epba_pkg::slot_index(ep_ff, step_sel);
      mem_ctrl.wr_data   = alloc_res.addr;
      mem_ctrl.clr_addr0 = epba_pkg::slot_index(req_ep_index, 1'b0);
      mem_ctrl.clr_addr1 = epba_pkg::slot_index(req_ep_index, 1'b1);

      case (state_ff)
         epba_pkg::ST_IDLE: begin
            if (req_fire) begin
               ep_in     = req_ep_index;
               ep_ok_in  = req_ep_ok;
               size_e_in = req_size_e;
               rsz_in    = req_rsz;
               step_in   = '0;
               en_in     = {phase_b && req_two, phase_b, phase_a && req_two, phase_a};
               status_in = 1'b0;
               rxcnt_in  = '0;
               if (!req_ep_ok) begin
                  status_in = (req_op == epba_pkg::OP_CONFIG);
                  slot0_in  = '0;
                  state_in  = epba_pkg::ST_LOAD;
               end else if (req_op == epba_pkg::OP_CONFIG) begin
                  if (!req_is_in) begin
                     rxcnt_in = req_rx;
                  end
                  state_in = epba_pkg::ST_SETUP;
               end else begin
                  mem_ctrl.clr_one = (req_op == epba_pkg::OP_RELEASE);
                  mem_ctrl.clr_all = (req_op == epba_pkg::OP_RELEASE_ALL);
                  state_in = epba_pkg::ST_READ0;
               end
            end
         end
         epba_pkg::ST_SETUP: begin
            if (step_ff == 3'd4) begin
               state_in = epba_pkg::ST_READ0;
            end else if (en_ff[step_ff[1:0]]) begin
               alloc_start = 1'b1;
               state_in    = epba_pkg::ST_SCAN;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         epba_pkg::ST_SCAN: begin
            if (alloc_res.done) begin
               if (alloc_res.fail) begin
                  status_in = 1'b1;
                  state_in  = epba_pkg::ST_READ0;
               end else begin
                  mem_ctrl.wr_en = 1'b1;
                  step_in        = step_ff + 3'd1;
                  state_in       = epba_pkg::ST_SETUP;
               end
            end
         end
         epba_pkg::ST_READ0: begin
            own_rd_addr = epba_pkg::slot_index(ep_ff, 1'b0);
            state_in    = epba_pkg::ST_READ1;
         end
         epba_pkg::ST_READ1: begin
            slot0_in = mem_rd_data;
            state_in = epba_pkg::ST_LOAD;
         end
         epba_pkg::ST_LOAD: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = epba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = epba_pkg::ST_IDLE;
         end
      endcase
   end

   assign mem_rd_addr  = (state_ff == epba_pkg::ST_SCAN) ? alloc_rd_addr : own_rd_addr;
   assign rsp_valid_in = load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= epba_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ep_ff     <= ep_in;
      ep_ok_ff  <= ep_ok_in;
      size_e_ff <= size_e_in;
      rsz_ff    <= rsz_in;
      rxcnt_ff  <= rxcnt_in;
      en_ff     <= en_in;
      status_ff <= status_in;
      slot0_ff  <= slot0_in;
      if (load_out) begin
         rsp_status_ff <= status_ff;
         rsp_slot0_ff  <= slot0_ff;
         rsp_slot1_ff  <= ep_ok_ff ? mem_rd_data : '0;
         rsp_rx_ff     <= rxcnt_ff;
      end
   end

   epba_slot_mem u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mem_ctrl),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   epba_alloc_unit u_alloc (
      .clock   (clock),
      .reset   (reset),
      .start   (alloc_start),
      .size    (alloc_size),
      .mem_top (mem_bytes_ff),
      .rd_data (mem_rd_data),
      .rd_addr (alloc_rd_addr),
      .res     (alloc_res)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot0_addr    = rsp_slot0_ff;
   assign rsp_slot1_addr    = rsp_slot1_ff;
   assign rsp_rx_count_word = rsp_rx_ff;

   `ASSERT_NEVER(a_done_outside_scan, alloc_res.done && (state_ff != epba_pkg::ST_SCAN), "alloc done outside scan")
   `ASSERT_ALWAYS(a_write_above_table, mem_ctrl.wr_en |-> (mem_ctrl.wr_data >= epba_pkg::ADDR_W'(epba_pkg::TABLE_BYTES)), "slot written inside descriptor table")
   `ASSERT_ALWAYS(a_fail_stops, (state_ff == epba_pkg::ST_SCAN) && alloc_res.done && alloc_res.fail |=> (state_ff == epba_pkg::ST_READ0) && status_ff, "allocation kept going after a failure")

endmodule

`default_nettype wire

[design/epba_slot_mem.sv]
// slot address store: 16 x 11 bit memory with per-entry valid bits
// one write port, one registered read port; depends on epba_pkg
`timescale 1ns / 1ps
`default_nettype none

module epba_slot_mem (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire epba_pkg::mem_ctrl_type            ctrl,
   input  wire logic [epba_pkg::SLOT_W-1:0]       rd_addr,
   output logic      [epba_pkg::ADDR_W-1:0]       rd_data
);

   logic [epba_pkg::ADDR_W-1:0] mem_ff [epba_pkg::NUM_SLOTS];
   logic [epba_pkg::NUM_SLOTS-1:0] valid_ff;
   logic [epba_pkg::NUM_SLOTS-1:0] valid_in;
   logic [epba_pkg::ADDR_W-1:0] rd_data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clr_all) begin
         valid_in = '0;
      end else if (ctrl.clr_one) begin
         valid_in[ctrl.clr_addr0] = 1'b0;
         valid_in[ctrl.clr_addr1] = 1'b0;
      end else if (ctrl.wr_en) begin
         valid_in[ctrl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/epba_alloc_unit.sv]
// allocation unit: scans all slots one a cycle for the lowest address in use,
// then checks the fit above the descriptor table; depends on epba_pkg
`timescale 1ns / 1ps
`default_nettype none

module epba_alloc_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [epba_pkg::ADDR_W-1:0]       size,
   input  wire logic [epba_pkg::ADDR_W-1:0]       mem_top,
   input  wire logic [epba_pkg::ADDR_W-1:0]       rd_data,
   output logic      [epba_pkg::SLOT_W-1:0]       rd_addr,
   output epba_pkg::alloc_res_type                res
);

   logic                        busy_ff, busy_in;
   logic                        pend_ff, pend_in;
   logic [epba_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [epba_pkg::ADDR_W-1:0] low_ff, low_in;
   logic [epba_pkg::ADDR_W-1:0] size_ff, size_in;
   logic                        issue;
   logic [epba_pkg::SUM_W-1:0]  need;

   always_comb begin
      issue   = busy_ff && (cnt_ff != epba_pkg::CNT_W'(epba_pkg::NUM_SLOTS));
      rd_addr = cnt_ff[epba_pkg::SLOT_W-1:0];
      need    = epba_pkg::SUM_W'(epba_pkg::TABLE_BYTES) + {1'b0, size_ff};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      low_in  = low_ff;
      size_in = size_ff;
      pend_in = issue;

      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (pend_ff && (rd_data != '0) && (rd_data < low_ff)) begin
         low_in = rd_data;
      end

      res.done = busy_ff && !issue && !pend_ff;
      res.fail = {1'b0, low_ff} < need;
      res.addr = low_ff - size_ff;

      if (res.done) begin
         busy_in = 1'b0;
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         low_in  = mem_top;
         size_in = size;
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff  <= low_in;
      size_ff <= size_in;
   end

endmodule

`default_nettype wire
